### hdl/tsra_pkg.sv
`timescale 1ns / 1ps
package tsra_pkg;

    localparam int SLOT_W = 6;
    localparam int LIVE_W = 7;

    typedef enum logic [1:0] {
        OP_SPAWN = 2'd0,
        OP_FREE  = 2'd1,
        OP_YIELD = 2'd2,
        OP_EXIT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_LIVE = 2'd2
    } t_status;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot_out;
        logic [SLOT_W-1:0] current;
        logic              ring_empty;
        logic [LIVE_W-1:0] live_count;
    } t_result;

endpackage

### hdl/tsra_ram.sv
`timescale 1ns / 1ps
module tsra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/tsra_fifo.sv
`timescale 1ns / 1ps
module tsra_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

### hdl/tsra_engine.sv
`timescale 1ns / 1ps
module tsra_engine #(
    parameter int SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  tsra_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output tsra_pkg::t_result o_res
);
    import tsra_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = CW + 1;
    localparam logic [XW-1:0] SLOTS_X = XW'(SLOTS);

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_DEC  = 8'b0000_0100,
        S_SP2  = 8'b0000_1000,
        S_F1   = 8'b0001_0000,
        S_F2   = 8'b0010_0000,
        S_F3   = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [SW:0]   r_cnt, n_cnt;
    t_op           r_op, n_op;
    logic [SW-1:0] r_s, n_s;
    logic          r_rng, n_rng;
    logic [SW-1:0] r_head, n_head;
    logic          r_head_v, n_head_v;
    logic [SW-1:0] r_fhead, n_fhead;
    logic          r_fvalid, n_fvalid;
    logic [CW-1:0] r_live, n_live;
    t_status       r_status, n_status;
    logic          r_spawned, n_spawned;
    logic [SW-1:0] r_e, n_e;
    logic [SW-1:0] r_p, n_p;
    logic [SW-1:0] r_q, n_q;
    logic [SW-1:0] r_nx, n_nx;
    logic [CW-1:0] r_sz, n_sz;
    logic [CW-1:0] r_sp, n_sp;
    logic          r_shave, n_shave;
    logic          r_alone, n_alone;
    logic          r_merged, n_merged;
    logic          r_hv_old, n_hv_old;

    logic          rn_we, rp_we, fn_we, fp_we, rs_we, rb_we, lf_we;
    logic [SW-1:0] rn_wa, rp_wa, fn_wa, fp_wa, rs_wa, rb_wa, lf_wa;
    logic [SW-1:0] rn_wd, rp_wd, fn_wd, fp_wd;
    logic [CW-1:0] rs_wd, rb_wd;
    logic          lf_wd;
    logic [SW-1:0] rn_ra, rp_ra, fn_ra, fp_ra, rs_ra, rb_ra, lf_ra;
    logic [SW-1:0] rn_q, rp_q, fn_q, fp_q;
    logic [CW-1:0] rs_q, rb_q;
    logic          lf_q;

    logic [SW-1:0] c_s;
    logic          c_rng;
    logic [XW-1:0] s_next_x, dfs_x, sp2_fs_x, sp2_nb, f1_nb, f1_pb_x, f2_pb_x, f2_nb;
    logic [SW-1:0] s_succ, d_fs, sp2_fs;
    logic          d_shave, d_alone, ok;
    logic          f1_merged, f1_alone, f2_left;
    logic [CW-1:0] f1_size, f2_sum;
    logic [SW-1:0] cur;

    assign c_s   = SW'(i_cmd.slot);
    assign c_rng = ({26'd0, i_cmd.slot} < 32'(SLOTS));
    assign ok    = r_rng && lf_q;

    assign s_next_x = XW'(r_s) + XW'(1);
    assign s_succ   = s_next_x[SW-1:0];
    assign dfs_x    = XW'(r_fhead) + XW'(1);
    assign d_fs     = dfs_x[SW-1:0];
    assign d_shave  = (rs_q > CW'(1)) && (dfs_x < SLOTS_X);
    assign d_alone  = (fn_q == r_fhead);
    assign sp2_fs_x = XW'(r_e) + XW'(1);
    assign sp2_fs   = sp2_fs_x[SW-1:0];
    assign sp2_nb   = XW'(r_e) + XW'(r_sz);

    assign f1_merged = (s_next_x < SLOTS_X) && (rs_q != '0);
    assign f1_alone  = (fn_q == s_succ);
    assign f1_size   = rs_q + CW'(1);
    assign f1_nb     = s_next_x + XW'(rs_q);
    assign f1_pb_x   = XW'(r_s) - XW'(rb_q);

    assign f2_left = (r_sp != '0) && (XW'(r_sp) <= XW'(r_s)) && (rs_q != '0);
    assign f2_pb_x = XW'(r_s) - XW'(r_sp);
    assign f2_sum  = rs_q + r_sz;
    assign f2_nb   = XW'(r_s) + XW'(r_sz);

    always_comb begin
        n_state = r_state;  n_cnt = r_cnt;  n_op = r_op;  n_s = r_s;  n_rng = r_rng;
        n_head = r_head;  n_head_v = r_head_v;  n_fhead = r_fhead;  n_fvalid = r_fvalid;
        n_live = r_live;  n_status = r_status;  n_spawned = r_spawned;
        n_e = r_e;  n_p = r_p;  n_q = r_q;  n_nx = r_nx;  n_sz = r_sz;  n_sp = r_sp;
        n_shave = r_shave;  n_alone = r_alone;  n_merged = r_merged;  n_hv_old = r_hv_old;
        rn_we = 1'b0;  rn_wa = '0;  rn_wd = '0;
        rp_we = 1'b0;  rp_wa = '0;  rp_wd = '0;
        fn_we = 1'b0;  fn_wa = '0;  fn_wd = '0;
        fp_we = 1'b0;  fp_wa = '0;  fp_wd = '0;
        rs_we = 1'b0;  rs_wa = '0;  rs_wd = '0;
        rb_we = 1'b0;  rb_wa = '0;  rb_wd = '0;
        lf_we = 1'b0;  lf_wa = '0;  lf_wd = 1'b0;
        rn_ra = r_head;  rp_ra = r_s;  lf_ra = r_s;  rb_ra = r_s;
        rs_ra = r_fhead;  fn_ra = r_fhead;  fp_ra = r_fhead;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;

        unique case (r_state)
            S_CLR: begin
                rs_we = 1'b1;  rs_wa = r_cnt[SW-1:0];
                rs_wd = (r_cnt == '0) ? CW'(SLOTS) : '0;
                rb_we = 1'b1;  rb_wa = r_cnt[SW-1:0];
                fn_we = 1'b1;  fn_wa = r_cnt[SW-1:0];
                fp_we = 1'b1;  fp_wa = r_cnt[SW-1:0];
                lf_we = 1'b1;  lf_wa = r_cnt[SW-1:0];
                n_cnt = r_cnt + (SW+1)'(1);
                if (r_cnt == (SW+1)'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_status  = ST_OK;
                n_spawned = 1'b0;
                rp_ra = c_s;
                lf_ra = c_s;
                rn_ra = (i_cmd.op == OP_FREE || i_cmd.op == OP_YIELD) ? c_s : r_head;
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    n_op  = i_cmd.op;
                    n_s   = c_s;
                    n_rng = c_rng;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_DONE;
                unique case (r_op)
                    OP_SPAWN: begin
                        if (!r_fvalid) begin
                            n_status = ST_FULL;
                        end else begin
                            n_e = r_fhead;  n_sz = rs_q;  n_p = fp_q;  n_q = fn_q;
                            n_shave = d_shave;  n_alone = d_alone;
                            n_nx = rn_q;  n_hv_old = r_head_v;
                            if (d_shave) begin
                                // shave the head run: its remainder starts one slot up
                                n_fhead = d_fs;
                                rs_we = 1'b1;  rs_wa = d_fs;  rs_wd = rs_q - CW'(1);
                                rb_we = 1'b1;  rb_wa = d_fs;  rb_wd = CW'(1);
                                fn_we = 1'b1;  fn_wa = d_fs;  fn_wd = d_alone ? d_fs : fn_q;
                                fp_we = 1'b1;  fp_wa = d_fs;  fp_wd = d_alone ? d_fs : fp_q;
                            end else begin
                                rs_we = 1'b1;  rs_wa = r_fhead;
                                if (d_alone) begin
                                    n_fvalid = 1'b0;
                                end else begin
                                    n_fhead = fn_q;
                                    fn_we = 1'b1;  fn_wa = fp_q;  fn_wd = fn_q;
                                    fp_we = 1'b1;  fp_wa = fn_q;  fp_wd = fp_q;
                                end
                            end
                            rn_we = 1'b1;  rn_wa = r_fhead;  rn_wd = r_head_v ? rn_q : r_fhead;
                            rp_we = 1'b1;  rp_wa = r_fhead;  rp_wd = r_head_v ? r_head : r_fhead;
                            lf_we = 1'b1;  lf_wa = r_fhead;  lf_wd = 1'b1;
                            if (!r_head_v) begin
                                n_head   = r_fhead;
                                n_head_v = 1'b1;
                            end
                            n_live    = r_live + CW'(1);
                            n_spawned = 1'b1;
                            n_state   = S_SP2;
                        end
                    end
                    OP_FREE: begin
                        if (!ok) begin
                            n_status = ST_NOT_LIVE;
                        end else begin
                            if (rn_q == r_s) begin
                                n_head_v = 1'b0;
                            end else begin
                                rp_we = 1'b1;  rp_wa = rn_q;  rp_wd = rp_q;
                                rn_we = 1'b1;  rn_wa = rp_q;  rn_wd = rn_q;
                                if (r_head == r_s) begin
                                    n_head = rn_q;
                                end
                            end
                            lf_we = 1'b1;  lf_wa = r_s;
                            n_live = r_live - CW'(1);
                            rs_ra = s_succ;  fn_ra = s_succ;  fp_ra = s_succ;
                            n_state = S_F1;
                        end
                    end
                    OP_YIELD: begin
                        if (!ok) begin
                            n_status = ST_NOT_LIVE;
                        end else if (rn_q != r_s) begin
                            n_head = rn_q;
                        end
                    end
                    OP_EXIT: begin
                        if (!r_head_v) begin
                            n_status = ST_NOT_LIVE;
                        end else begin
                            n_head = rn_q;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SP2: begin
                if (r_shave) begin
                    rs_we = 1'b1;  rs_wa = r_e;
                    if (sp2_nb < SLOTS_X) begin
                        rb_we = 1'b1;  rb_wa = sp2_nb[SW-1:0];  rb_wd = r_sz - CW'(1);
                    end
                    if (!r_alone) begin
                        fn_we = 1'b1;  fn_wa = r_p;  fn_wd = sp2_fs;
                        fp_we = 1'b1;  fp_wa = r_q;  fp_wd = sp2_fs;
                    end
                end
                if (r_hv_old) begin
                    rn_we = 1'b1;  rn_wa = r_head;  rn_wd = r_e;
                    rp_we = 1'b1;  rp_wa = r_nx;    rp_wd = r_e;
                end
                n_state = S_DONE;
            end
            S_F1: begin
                n_merged = f1_merged;
                n_sz     = f1_merged ? f1_size : CW'(1);
                n_sp     = rb_q;
                n_alone  = f1_alone;
                n_p      = f1_alone ? r_s : fp_q;
                n_q      = f1_alone ? r_s : fn_q;
                if (f1_merged) begin
                    // absorb the run on the right into the released slot
                    rs_we = 1'b1;  rs_wa = s_succ;
                    if (f1_nb < SLOTS_X) begin
                        rb_we = 1'b1;  rb_wa = f1_nb[SW-1:0];  rb_wd = f1_size;
                    end
                    fn_we = 1'b1;  fp_we = 1'b1;
                    if (f1_alone) begin
                        fn_wa = r_s;   fn_wd = r_s;
                        fp_wa = r_s;   fp_wd = r_s;
                    end else begin
                        fn_wa = fp_q;  fn_wd = r_s;
                        fp_wa = fn_q;  fp_wd = r_s;
                    end
                    if (r_fhead == s_succ) begin
                        n_fhead = r_s;
                    end
                end
                rs_ra = f1_pb_x[SW-1:0];
                fp_ra = r_fhead;
                n_state = S_F2;
            end
            S_F2: begin
                n_state = S_DONE;
                if (f2_left) begin
                    rs_we = 1'b1;  rs_wa = f2_pb_x[SW-1:0];  rs_wd = f2_sum;
                    if (f2_nb < SLOTS_X) begin
                        rb_we = 1'b1;  rb_wa = f2_nb[SW-1:0];  rb_wd = f2_sum;
                    end
                    if (r_merged) begin
                        // drop the released slot from the free list again
                        fn_we = 1'b1;  fn_wa = r_p;  fn_wd = r_q;
                        fp_we = 1'b1;  fp_wa = r_q;  fp_wd = r_p;
                        if (r_fhead == r_s) begin
                            n_fhead = r_q;
                        end
                    end
                end else if (r_merged) begin
                    rs_we = 1'b1;  rs_wa = r_s;  rs_wd = r_sz;
                    if (!r_alone) begin
                        fn_we = 1'b1;  fn_wa = r_s;  fn_wd = r_q;
                        fp_we = 1'b1;  fp_wa = r_s;  fp_wd = r_p;
                    end
                end else begin
                    rs_we = 1'b1;  rs_wa = r_s;  rs_wd = CW'(1);
                    if (!r_fvalid) begin
                        n_fhead  = r_s;
                        n_fvalid = 1'b1;
                        fn_we = 1'b1;  fn_wa = r_s;  fn_wd = r_s;
                        fp_we = 1'b1;  fp_wa = r_s;  fp_wd = r_s;
                    end else begin
                        // append at the tail of the free list
                        fp_we = 1'b1;  fp_wa = r_s;  fp_wd = fp_q;
                        fn_we = 1'b1;  fn_wa = r_s;  fn_wd = r_fhead;
                        n_p = fp_q;
                        n_state = S_F3;
                    end
                end
            end
            S_F3: begin
                fn_we = 1'b1;  fn_wa = r_p;      fn_wd = r_s;
                fp_we = 1'b1;  fp_wa = r_fhead;  fp_wd = r_s;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res_push = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_cnt     <= '0;
            r_head    <= '0;
            r_head_v  <= 1'b0;
            r_fhead   <= '0;
            r_fvalid  <= 1'b1;
            r_live    <= '0;
            r_status  <= ST_OK;
            r_spawned <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_head    <= n_head;
            r_head_v  <= n_head_v;
            r_fhead   <= n_fhead;
            r_fvalid  <= n_fvalid;
            r_live    <= n_live;
            r_status  <= n_status;
            r_spawned <= n_spawned;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_s      <= n_s;
        r_rng    <= n_rng;
        r_e      <= n_e;
        r_p      <= n_p;
        r_q      <= n_q;
        r_nx     <= n_nx;
        r_sz     <= n_sz;
        r_sp     <= n_sp;
        r_shave  <= n_shave;
        r_alone  <= n_alone;
        r_merged <= n_merged;
        r_hv_old <= n_hv_old;
    end

    tsra_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_ring_next (
        .i_clk(i_clk), .i_we(rn_we), .i_waddr(rn_wa), .i_wdata(rn_wd),
        .i_raddr(rn_ra), .o_rdata(rn_q));
    tsra_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_ring_prev (
        .i_clk(i_clk), .i_we(rp_we), .i_waddr(rp_wa), .i_wdata(rp_wd),
        .i_raddr(rp_ra), .o_rdata(rp_q));
    tsra_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_free_next (
        .i_clk(i_clk), .i_we(fn_we), .i_waddr(fn_wa), .i_wdata(fn_wd),
        .i_raddr(fn_ra), .o_rdata(fn_q));
    tsra_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_free_prev (
        .i_clk(i_clk), .i_we(fp_we), .i_waddr(fp_wa), .i_wdata(fp_wd),
        .i_raddr(fp_ra), .o_rdata(fp_q));
    tsra_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_run_size (
        .i_clk(i_clk), .i_we(rs_we), .i_waddr(rs_wa), .i_wdata(rs_wd),
        .i_raddr(rs_ra), .o_rdata(rs_q));
    tsra_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_run_before (
        .i_clk(i_clk), .i_we(rb_we), .i_waddr(rb_wa), .i_wdata(rb_wd),
        .i_raddr(rb_ra), .o_rdata(rb_q));
    tsra_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_live_flag (
        .i_clk(i_clk), .i_we(lf_we), .i_waddr(lf_wa), .i_wdata(lf_wd),
        .i_raddr(lf_ra), .o_rdata(lf_q));

    assign cur = r_head_v ? r_head : '0;
    assign o_res.status     = r_status;
    assign o_res.slot_out   = SLOT_W'(r_spawned ? r_e : cur);
    assign o_res.current    = SLOT_W'(cur);
    assign o_res.ring_empty = !r_head_v;
    assign o_res.live_count = LIVE_W'(r_live);

endmodule

### hdl/task_slot_ring_allocator.sv
`timescale 1ns / 1ps
// Task slot ring allocator.
// Commands enter through a queue port: drive i_op/i_slot_in with push; a
// transaction is taken when push is high and full is low. Results leave
// through a queue port: while empty is low the oldest result sits on the
// o_* ports and is taken when pop is high.
// A two-entry command queue feeds a sequencer that works over the slot
// tables (one RAM per table, one read and one write each per cycle); a
// two-entry result queue decouples the receiver.
// After a command is taken the sequencer decodes it; yield, exit and
// rejected commands then go straight to done, spawn passes through SP2,
// and free through F1, F2 and, for a tail insert, F3. The table sequencer
// handles one command at a time and takes no new one until the result of
// the last has been pushed.
// After reset the sequencer sweeps the tables before the first command
// is executed; commands may still be queued meanwhile.
// When the receiver stalls, results wait in the result queue; once it is
// full the sequencer holds and the command queue fills, raising full.
module task_slot_ring_allocator #(
    parameter int SLOTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_op,
    input  logic [tsra_pkg::SLOT_W-1:0]   i_slot_in,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    o_status,
    output logic [tsra_pkg::SLOT_W-1:0]   o_slot_out,
    output logic [tsra_pkg::SLOT_W-1:0]   o_current,
    output logic                          o_ring_empty,
    output logic [tsra_pkg::LIVE_W-1:0]   o_live_count
);
    import tsra_pkg::*;

    t_cmd    in_cmd, cmd;
    t_result res, out_res;
    logic    cmd_empty, cmd_pop, res_full, res_push;

    assign in_cmd.op   = t_op'(i_op);
    assign in_cmd.slot = i_slot_in;

    tsra_fifo #(.WIDTH($bits(t_cmd))) u_cmd_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(in_cmd), .o_full(full),
        .i_pop(cmd_pop), .o_data(cmd), .o_empty(cmd_empty));

    tsra_engine #(.SLOTS(SLOTS)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(!cmd_empty), .i_cmd(cmd), .o_cmd_pop(cmd_pop),
        .i_res_full(res_full), .o_res_push(res_push), .o_res(res));

    tsra_fifo #(.WIDTH($bits(t_result))) u_res_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(res_push), .i_data(res), .o_full(res_full),
        .i_pop(pop), .o_data(out_res), .o_empty(empty));

    assign o_status     = out_res.status;
    assign o_slot_out   = out_res.slot_out;
    assign o_current    = out_res.current;
    assign o_ring_empty = out_res.ring_empty;
    assign o_live_count = out_res.live_count;

endmodule

### hdl/tsra_chk.sv
`timescale 1ns / 1ps
module tsra_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_status,
    input logic [5:0] o_slot_out,
    input logic [5:0] o_current,
    input logic       o_ring_empty,
    input logic [6:0] o_live_count
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_ring_empty == (o_live_count == 7'd0)))
        else $error("ring_empty disagrees with live_count");

    a_empty_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_ring_empty) |-> (o_current == 6'd0))
        else $error("current not zero on empty ring");

    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != 2'd0) |-> (o_slot_out == o_current && o_status != 2'd3))
        else $error("failed transaction reports a bad slot or status");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_live_count)))
        else $error("stalled result changed");

endmodule

bind task_slot_ring_allocator tsra_chk u_chk (.*);

### dv/task_slot_ring_allocator_test.sv
`timescale 1ns / 1ps
module task_slot_ring_allocator_test;
    import tsra_pkg::*;

    localparam int NSLOT = 64;
    localparam int N_RAND = 430;
    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic [1:0] i_op = OP_SPAWN;
    logic [SLOT_W-1:0] i_slot_in = '0;
    logic full, empty;
    logic [1:0] o_status;
    logic [SLOT_W-1:0] o_slot_out, o_current;
    logic o_ring_empty;
    logic [LIVE_W-1:0] o_live_count;

    task_slot_ring_allocator #(.SLOTS(NSLOT)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_op(i_op), .i_slot_in(i_slot_in), .empty(empty), .pop(pop),
        .o_status(o_status), .o_slot_out(o_slot_out), .o_current(o_current),
        .o_ring_empty(o_ring_empty), .o_live_count(o_live_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // allocator shadow state
    logic [5:0] rnext [NSLOT];
    logic [5:0] rprev [NSLOT];
    int unsigned rsz [NSLOT];
    int unsigned rszb [NSLOT];
    logic [5:0] fnext [NSLOT];
    logic [5:0] fprev [NSLOT];
    bit live [NSLOT];
    logic [5:0] cur_slot;
    bit cur_ok;
    logic [5:0] fhead;
    bit fhead_ok;
    int unsigned nlive;

    t_result pending_results[$];
    int errors = 0;
    int idle_cycles = 0;
    bit rx_hold = 1'b0;
    bit rx_calm = 1'b0;
    bit tx_calm = 1'b0;

    task automatic alloc_reset();
        for (int i = 0; i < NSLOT; i++) begin
            rnext[i] = '0; rprev[i] = '0; rsz[i] = 0; rszb[i] = 0;
            fnext[i] = '0; fprev[i] = '0; live[i] = 0;
        end
        rsz[0] = NSLOT;
        cur_slot = '0; cur_ok = 0; fhead = '0; fhead_ok = 1; nlive = 0;
    endtask

    function automatic logic [5:0] take_slot();
        logic [5:0] e, p, q, fs;
        int unsigned sz, nb;
        e = fhead;
        sz = rsz[e];
        if (sz <= 1 || e + 1 >= NSLOT) begin
            if (fnext[e] == e) fhead_ok = 0;
            else begin
                p = fprev[e]; q = fnext[e];
                fnext[p] = q; fprev[q] = p; fhead = q;
            end
        end else begin
            fs = 6'(e + 1);
            nb = e + sz;
            rsz[fs] = sz - 1;
            rszb[fs] = 1;
            if (fnext[e] == e) begin
                fnext[fs] = fs; fprev[fs] = fs;
            end else begin
                p = fprev[e]; q = fnext[e];
                fnext[fs] = q; fprev[fs] = p; fnext[p] = fs; fprev[q] = fs;
            end
            if (nb < NSLOT) rszb[nb] = sz - 1;
            fhead = fs;
        end
        rsz[e] = 0;
        return e;
    endfunction

    function automatic void give_back(logic [5:0] n);
        int unsigned size_n, ssz, nb, sp;
        bit merged;
        logic [5:0] s, p, q, pb, t;
        size_n = 1;
        merged = 0;
        if (n + 1 < NSLOT && rsz[n + 1] != 0) begin
            s = 6'(n + 1);
            ssz = rsz[s];
            nb = s + ssz;
            size_n = ssz + 1;
            if (fnext[s] == s) begin
                fnext[n] = n; fprev[n] = n;
            end else begin
                p = fprev[s]; q = fnext[s];
                fnext[p] = n; fprev[q] = n; fprev[n] = p; fnext[n] = q;
            end
            rsz[s] = 0;
            if (nb < NSLOT) rszb[nb] = size_n;
            if (fhead == s) fhead = n;
            merged = 1;
        end
        sp = rszb[n];
        if (sp != 0 && sp <= n) begin
            pb = 6'(n - sp);
            if (rsz[pb] != 0) begin
                nb = n + size_n;
                rsz[pb] = rsz[pb] + size_n;
                if (nb < NSLOT) rszb[nb] = rsz[pb];
                if (merged) begin
                    p = fprev[n]; q = fnext[n];
                    fnext[p] = q; fprev[q] = p;
                    if (fhead == n) fhead = q;
                end
                rsz[n] = 0;
                return;
            end
        end
        if (merged) begin
            rsz[n] = size_n;
            return;
        end
        rsz[n] = 1;
        if (!fhead_ok) begin
            fhead = n; fhead_ok = 1; fnext[n] = n; fprev[n] = n;
        end else begin
            t = fprev[fhead];
            fprev[n] = t; fnext[n] = fhead; fnext[t] = n; fprev[fhead] = n;
        end
    endfunction

    function automatic t_result alloc_step(t_op op, logic [5:0] s);
        t_result r;
        t_status st;
        logic [5:0] e, nx, pv;
        bit spawned;
        st = ST_OK;
        spawned = 0;
        e = '0;
        case (op)
            OP_SPAWN: begin
                if (!fhead_ok) st = ST_FULL;
                else begin
                    e = take_slot();
                    if (!cur_ok) begin
                        rnext[e] = e; rprev[e] = e; cur_slot = e; cur_ok = 1;
                    end else begin
                        nx = rnext[cur_slot]; pv = rprev[nx];
                        rnext[e] = nx; rprev[e] = pv; rprev[nx] = e; rnext[pv] = e;
                    end
                    live[e] = 1;
                    nlive++;
                    spawned = 1;
                end
            end
            OP_FREE: begin
                if (!live[s]) st = ST_NOT_LIVE;
                else begin
                    if (rnext[s] == s) cur_ok = 0;
                    else begin
                        nx = rnext[s]; pv = rprev[s];
                        rprev[nx] = pv; rnext[pv] = nx;
                        if (cur_slot == s) cur_slot = nx;
                    end
                    live[s] = 0;
                    nlive--;
                    give_back(s);
                end
            end
            OP_YIELD: begin
                if (!live[s]) st = ST_NOT_LIVE;
                else if (rnext[s] != s) cur_slot = rnext[s];
            end
            default: begin
                if (!cur_ok) st = ST_NOT_LIVE;
                else cur_slot = rnext[cur_slot];
            end
        endcase
        r.status = st;
        r.current = cur_ok ? cur_slot : '0;
        r.slot_out = spawned ? e : r.current;
        r.ring_empty = !cur_ok;
        r.live_count = 7'(nlive);
        return r;
    endfunction

    // directed table; typed rows also hold the predictor to a fixed expectation, all rows use the predictor
    typedef struct {
        t_op op;
        logic [5:0] slot;
        bit typed;
        t_result exp_r;
    } t_row;
    t_row rows[$];

    task automatic add_row(t_op op, logic [5:0] s, bit typed = 0,
                           t_result er = '0);
        t_row r;
        r.op = op; r.slot = s; r.typed = typed; r.exp_r = er;
        rows.push_back(r);
    endtask

    // push stays high after the transaction; callers drop it before they pause
    task automatic send_cmd(t_op op, logic [5:0] s, bit typed, t_result er);
        t_result pr;
        while (!tx_calm && $urandom_range(99) < 24) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_op <= op;
        i_slot_in <= s;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pr = alloc_step(op, s);
        if (typed && pr !== er) begin
            $error("table row result (op %0d slot %0d) exp %p got %p", op, s, er, pr);
            errors++;
        end
        pending_results.push_back(pr);
    endtask

    function automatic logic [5:0] pick_live();
        logic [5:0] c;
        c = 6'($urandom_range(NSLOT - 1));
        for (int i = 0; i < NSLOT; i++) begin
            if (live[(c + i) % NSLOT]) return 6'((c + i) % NSLOT);
        end
        return c;
    endfunction

    // receiver
    initial begin
        t_result got, want;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                got.status = t_status'(o_status);
                got.slot_out = o_slot_out;
                got.current = o_current;
                got.ring_empty = o_ring_empty;
                got.live_count = o_live_count;
                if (pending_results.size() == 0) begin
                    $error("result with nothing outstanding");
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, got.status); errors++;
                    end
                    if (got.slot_out !== want.slot_out) begin
                        $error("slot_out exp %0d got %0d", want.slot_out, got.slot_out);
                        errors++;
                    end
                    if (got.current !== want.current) begin
                        $error("current exp %0d got %0d", want.current, got.current); errors++;
                    end
                    if (got.ring_empty !== want.ring_empty) begin
                        $error("ring_empty exp %0d got %0d", want.ring_empty, got.ring_empty);
                        errors++;
                    end
                    if (got.live_count !== want.live_count) begin
                        $error("live_count exp %0d got %0d", want.live_count,
                               got.live_count);
                        errors++;
                    end
                end
            end
            pop <= !rx_hold && (rx_calm || $urandom_range(99) >= 24);
        end
    end

    // watchdog: count cycles with no transaction on either side
    initial begin
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("task_slot_ring_allocator_test: done, errors");
                $finish;
            end
        end
    end

    initial begin
        t_result er;
        t_op op;
        logic [5:0] s;
        int k;
        alloc_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty ring: exit, yield, free all rejected
        er = '{ST_NOT_LIVE, 6'd0, 6'd0, 1'b1, 7'd0};
        add_row(OP_EXIT, 6'd0, 1, er);
        add_row(OP_YIELD, 6'd63, 1, er);
        add_row(OP_FREE, 6'd63, 1, er);
        add_row(OP_FREE, 6'd0, 1, er);
        er = '{ST_OK, 6'd0, 6'd0, 1'b0, 7'd1};
        add_row(OP_SPAWN, 6'd63, 1, er);
        add_row(OP_YIELD, 6'd0, 1, er);     // lone slot
        add_row(OP_SPAWN, 6'd0);
        add_row(OP_SPAWN, 6'd21);
        add_row(OP_YIELD, 6'd2);            // not current
        add_row(OP_EXIT, 6'd42);
        add_row(OP_FREE, 6'd1);             // left merge impossible, tail insert
        add_row(OP_FREE, 6'd0);             // right merge
        add_row(OP_FREE, 6'd2);
        add_row(OP_FREE, 6'd2);
        add_row(OP_EXIT, 6'd0);
        for (int i = 0; i < rows.size(); i++)
            send_cmd(rows[i].op, rows[i].slot, rows[i].typed, rows[i].exp_r);

        // fill the table, then overflow
        for (int i = 0; i < NSLOT; i++) send_cmd(OP_SPAWN, 6'($urandom), 0, er);
        er = '{ST_FULL, cur_slot, cur_slot, 1'b0, 7'd64};
        send_cmd(OP_SPAWN, 6'd0, 1, er);
        send_cmd(OP_FREE, 6'd63, 0, er);
        send_cmd(OP_FREE, 6'd62, 0, er);

        // receiver holds off while the sender keeps pushing
        fork
            begin
                rx_hold = 1;
                repeat (300) @(posedge i_clk);
                rx_hold = 0;
            end
            for (int i = 0; i < 20; i++) send_cmd(OP_EXIT, 6'($urandom), 0, er);
        join

        // sender waits for the pipeline to drain
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);

        for (int i = 0; i < N_RAND; i++) begin
            tx_calm = (i >= 200 && i < 300);
            rx_calm = tx_calm;
            k = $urandom_range(99);
            if (k < 35) op = OP_SPAWN;
            else if (k < 70) op = OP_FREE;
            else if (k < 85) op = OP_YIELD;
            else op = OP_EXIT;
            s = (k % 7 == 0) ? 6'($urandom) : pick_live();
            send_cmd(op, s, 0, er);
            // now and then drain the table entirely
            if (i % 150 == 149) begin
                for (int j = 0; j < NSLOT; j++)
                    if (live[j]) send_cmd(OP_FREE, 6'(j), 0, er);
            end
        end
        tx_calm = 0;
        rx_calm = 0;

        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("task_slot_ring_allocator_test: done, clean");
        else $display("task_slot_ring_allocator_test: done, errors");
        $finish;
    end

endmodule
